@@ rtl/ccc_pkg.sv @@
package ccc_pkg;

  typedef struct packed {
    logic        mode;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [4:0]  load_day;
    logic [3:0]  load_month;
    logic [13:0] load_year;
    logic [2:0]  load_weekday;
  } ccc_in_t;

  typedef struct packed {
    logic [5:0]  second_now;
    logic [5:0]  minute_now;
    logic [4:0]  hour_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [13:0] year_now;
    logic [2:0]  weekday_now;
    logic        leap_now;
    logic        day_rolled;
  } ccc_out_t;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [13:0] YEAR_LAST  = 14'd9999;
  localparam logic [2:0]  WDAY_LAST  = 3'd6;

  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [13:0] YEAR_RST    = 14'd2000;
  localparam logic [2:0]  WDAY_RST    = 3'd6;
  localparam logic        LEAP_RST    = 1'b1;

  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;

  localparam logic [4:0] DAYS_28 = 5'd28;
  localparam logic [4:0] DAYS_29 = 5'd29;
  localparam logic [4:0] DAYS_30 = 5'd30;
  localparam logic [4:0] DAYS_31 = 5'd31;

  // y divisible by 25 iff (y * 25^-1 mod 2^14) <= floor((2^14-1)/25)
  localparam logic [13:0] MOD25_INV = 14'd7209;
  localparam logic [13:0] MOD25_LIM = 14'd655;

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m) inside
      MON_FEB:                            len = leap ? DAYS_29 : DAYS_28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_30;
      default:                            len = DAYS_31;
    endcase
    return len;
  endfunction

  function automatic logic is_leap(logic [13:0] y);
    logic [13:0] p;
    logic        div25;
    p     = y * MOD25_INV;
    div25 = (p <= MOD25_LIM);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

endpackage

@@ rtl/ccc_in_if.sv @@
interface ccc_in_if;
  logic             valid;
  logic             ready;
  ccc_pkg::ccc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ccc_out_if.sv @@
interface ccc_out_if;
  logic              valid;
  logic              ready;
  ccc_pkg::ccc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/clock_calendar_counter.sv @@
// Time-of-day and Gregorian calendar counter.
// in_ch: one word per tick or load. mode 0 advances one second, carrying
//   into minutes, hours, day, month and year (year wraps 9999 -> 0); the
//   weekday advances on every new day. mode 1 loads all fields as given.
// out_ch: one word per input word, the full time and date after it, the
//   leap flag of the current year and a flag set when a tick crossed
//   midnight.
// Each result is registered in the output word, or in the skid word.
// Throughput: one word per cycle while the skid word is empty; the
//   update is one compare/increment pass plus a 14-bit leap multiply.
// Stall: an output register and a one-word skid register follow the
//   counter, so an input word is still taken while a result waits; in_ch
//   ready drops only when both hold words.
// Reset (rst_n, synchronous): 00:00:00, day 1, month 1, year 2000,
//   Saturday (weekday 6), leap flag set; both output words empty.
module clock_calendar_counter (
  input logic     clk,
  input logic     rst_n,
  ccc_in_if.sink    in_ch,
  ccc_out_if.source out_ch
);
  import ccc_pkg::*;

  logic [5:0]  sec_r, sec_nxt;
  logic [5:0]  min_r, min_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [13:0] year_r, year_nxt;
  logic [2:0]  wday_r, wday_nxt;
  logic        leap_r, leap_nxt;
  logic        rolled;

  logic        accept;
  ccc_in_t     in_w;
  ccc_out_t    res_w;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  ccc_out_t    out_word_r, out_word_nxt;
  ccc_out_t    skid_word_r, skid_word_nxt;

  assign in_w         = in_ch.data;
  assign in_ch.ready  = !skid_valid_r;
  assign accept       = in_ch.valid && !skid_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_word_r;

  // calendar update
  always_comb begin
    sec_nxt   = sec_r;
    min_nxt   = min_r;
    hour_nxt  = hour_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    wday_nxt  = wday_r;
    rolled    = 1'b0;
    if (accept) begin
      if (in_w.mode == MODE_LOAD) begin
        sec_nxt   = in_w.load_second;
        min_nxt   = in_w.load_minute;
        hour_nxt  = in_w.load_hour;
        day_nxt   = in_w.load_day;
        month_nxt = in_w.load_month;
        year_nxt  = in_w.load_year;
        wday_nxt  = in_w.load_weekday;
      end else if (sec_r < SEC_LAST) begin
        sec_nxt = sec_r + 6'd1;
      end else begin
        sec_nxt = '0;
        if (min_r < MIN_LAST) begin
          min_nxt = min_r + 6'd1;
        end else begin
          min_nxt = '0;
          if (hour_r < HOUR_LAST) begin
            hour_nxt = hour_r + 5'd1;
          end else begin
            hour_nxt = '0;
            rolled   = 1'b1;
            wday_nxt = (wday_r >= WDAY_LAST) ? 3'd0 : wday_r + 3'd1;
            if (day_r < month_len(month_r, leap_r)) begin
              day_nxt = day_r + 5'd1;
            end else begin
              day_nxt = DAY_FIRST;
              if (month_r < MONTH_LAST) begin
                month_nxt = month_r + 4'd1;
              end else begin
                month_nxt = MONTH_FIRST;
                year_nxt  = (year_r >= YEAR_LAST) ? 14'd0 : year_r + 14'd1;
              end
            end
          end
        end
      end
    end
    leap_nxt = is_leap(year_nxt);
  end

  always_comb begin
    res_w.second_now  = sec_nxt;
    res_w.minute_now  = min_nxt;
    res_w.hour_now    = hour_nxt;
    res_w.day_now     = day_nxt;
    res_w.month_now   = month_nxt;
    res_w.year_now    = year_nxt;
    res_w.weekday_now = wday_nxt;
    res_w.leap_now    = leap_nxt;
    res_w.day_rolled  = rolled;
  end

  // output register plus skid word
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      if (!out_valid_r || out_ch.ready) begin
        out_word_nxt = res_w;
      end else begin
        skid_word_nxt  = res_w;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_valid_r && out_ch.ready) begin
      if (skid_valid_r) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r        <= '0;
      min_r        <= '0;
      hour_r       <= '0;
      day_r        <= DAY_FIRST;
      month_r      <= MONTH_FIRST;
      year_r       <= YEAR_RST;
      wday_r       <= WDAY_RST;
      leap_r       <= LEAP_RST;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      sec_r        <= sec_nxt;
      min_r        <= min_nxt;
      hour_r       <= hour_nxt;
      day_r        <= day_nxt;
      month_r      <= month_nxt;
      year_r       <= year_nxt;
      wday_r       <= wday_nxt;
      leap_r       <= leap_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_rollover_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && rolled) |=> (sec_r == 6'd0 && min_r == 6'd0 && hour_r == 5'd0))
    else $error("midnight rollover left time nonzero");

  a_load_year: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_w.mode == MODE_LOAD) |=> (year_r == $past(in_w.load_year)))
    else $error("load did not store year");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (!out_valid_r || out_ch.ready)) |=>
      (out_word_r.year_now == year_r && out_word_r.second_now == sec_r))
    else $error("result word differs from calendar state");

endmodule

@@ tb/sv/clock_calendar_counter_tb.sv @@
module clock_calendar_counter_tb;
  import ccc_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  ccc_in_if  in_ch();
  ccc_out_if out_ch();

  clock_calendar_counter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ccc_in_t  pending_words[$];
  ccc_out_t expected_stamps[$];
  int       mismatch_count = 0;

  // calendar state as the block should hold it
  logic [5:0]  cal_sec   = '0;
  logic [5:0]  cal_min   = '0;
  logic [4:0]  cal_hour  = '0;
  logic [4:0]  cal_day   = DAY_FIRST;
  logic [3:0]  cal_month = MONTH_FIRST;
  logic [13:0] cal_year  = YEAR_RST;
  logic [2:0]  cal_wday  = WDAY_RST;
  logic        cal_leap  = LEAP_RST;

  function automatic logic leap_year(int y);
    if (y % 400 == 0) return 1'b1;
    if (y % 100 == 0) return 1'b0;
    return (y % 4 == 0);
  endfunction

  function automatic int days_in_month(int m, logic leap);
    if (m == MON_FEB) return leap ? DAYS_29 : DAYS_28;
    if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) return DAYS_30;
    return DAYS_31;
  endfunction

  function automatic ccc_out_t next_stamp(ccc_in_t w);
    ccc_out_t r;
    logic     rolled;
    rolled = 1'b0;
    if (w.mode == MODE_LOAD) begin
      cal_sec   = w.load_second;
      cal_min   = w.load_minute;
      cal_hour  = w.load_hour;
      cal_day   = w.load_day;
      cal_month = w.load_month;
      cal_year  = w.load_year;
      cal_wday  = w.load_weekday;
      cal_leap  = leap_year(w.load_year);
    end else if (cal_sec < SEC_LAST) begin
      cal_sec = cal_sec + 1'b1;
    end else begin
      cal_sec = '0;
      if (cal_min < MIN_LAST) begin
        cal_min = cal_min + 1'b1;
      end else begin
        cal_min = '0;
        if (cal_hour < HOUR_LAST) begin
          cal_hour = cal_hour + 1'b1;
        end else begin
          cal_hour = '0;
          rolled   = 1'b1;
          cal_wday = (cal_wday >= WDAY_LAST) ? 3'd0 : cal_wday + 1'b1;
          if (cal_day < days_in_month(cal_month, cal_leap)) begin
            cal_day = cal_day + 1'b1;
          end else begin
            cal_day = DAY_FIRST;
            if (cal_month < MONTH_LAST) begin
              cal_month = cal_month + 1'b1;
            end else begin
              cal_month = MONTH_FIRST;
              cal_year  = (cal_year >= YEAR_LAST) ? 14'd0 : cal_year + 1'b1;
              cal_leap  = leap_year(cal_year);
            end
          end
        end
      end
    end
    r.second_now  = cal_sec;
    r.minute_now  = cal_min;
    r.hour_now    = cal_hour;
    r.day_now     = cal_day;
    r.month_now   = cal_month;
    r.year_now    = cal_year;
    r.weekday_now = cal_wday;
    r.leap_now    = cal_leap;
    r.day_rolled  = rolled;
    return r;
  endfunction

  function automatic string stamp_str(ccc_out_t s);
    return $sformatf("%0d:%0d:%0d d%0d m%0d y%0d wd%0d leap%0b roll%0b",
                     s.hour_now, s.minute_now, s.second_now, s.day_now, s.month_now,
                     s.year_now, s.weekday_now, s.leap_now, s.day_rolled);
  endfunction

  // ticks carry random payload, which the block must ignore
  function automatic void add_ticks(int n);
    ccc_in_t     w;
    logic [63:0] rnd;
    repeat (n) begin
      rnd    = {$urandom, $urandom};
      w      = rnd[$bits(ccc_in_t)-1:0];
      w.mode = MODE_TICK;
      pending_words = {pending_words, w};
    end
  endfunction

  function automatic void add_load(int s, int mi, int h, int d, int mo, int y, int wd);
    ccc_in_t w;
    w.mode         = MODE_LOAD;
    w.load_second  = 6'(s);
    w.load_minute  = 6'(mi);
    w.load_hour    = 5'(h);
    w.load_day     = 5'(d);
    w.load_month   = 4'(mo);
    w.load_year    = 14'(y);
    w.load_weekday = 3'(wd);
    pending_words = {pending_words, w};
  endfunction

  function automatic int pick_year();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 9999);
      1:       return 100 * $urandom_range(0, 99);
      2:       return 4 * $urandom_range(0, 2499);
      3:       return $urandom_range(9998, 9999);
      4:       return $urandom_range(0, 16383);
      default: return $urandom_range(1999, 2001);
    endcase
  endfunction

  // load close to a rollover, then tick toward it, often across it
  function automatic void add_near_rollover();
    int y, mo, d;
    y  = pick_year();
    mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) d = $urandom_range(0, 31);
    else d = days_in_month(mo, leap_year(y)) - $urandom_range(0, 1);
    add_load(SEC_LAST - $urandom_range(0, 3),
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : MIN_LAST,
             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : HOUR_LAST,
             d, mo, y, $urandom_range(0, 7));
    add_ticks($urandom_range(1, 30));
  endfunction

  function automatic void build_stimulus();
    ccc_in_t     w;
    logic [63:0] rnd;
    add_ticks(2);
    add_load(58, 59, 23, 31, 12, 9999, 6);
    add_ticks(2);
    add_load(59, 59, 23, 28, 2, 2024, 3);
    add_ticks(1);
    add_load(59, 59, 23, 29, 2, 2024, 4);
    add_ticks(1);
    add_load(59, 59, 23, 28, 2, 2100, 0);
    add_ticks(1);
    add_load(59, 59, 23, 30, 4, 2023, 5);
    add_ticks(1);
    add_load(63, 63, 31, 31, 15, 16383, 7);
    add_ticks(1);
    add_load(59, 59, 23, 0, 0, 0, 0);
    add_ticks(1);
    add_load(59, 59, 23, 31, 0, 400, 2);
    add_ticks(1);
    add_load(59, 59, 23, 30, 2, 2001, 1);
    add_ticks(1);
    add_load(0, 0, 0, 1, 1, 0, 0);
    add_load(59, 58, 22, 15, 6, 1999, 2);
    add_ticks(1);

    while (pending_words.size() < 1275) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          rnd    = {$urandom, $urandom};
          w      = rnd[$bits(ccc_in_t)-1:0];
          w.mode = MODE_LOAD;
          pending_words = {pending_words, w};
          add_ticks($urandom_range(1, 20));
        end
        2, 3: add_ticks($urandom_range(1, 40));
        default: add_near_rollover();
      endcase
    end
  endfunction

  // driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= $urandom_range(1, 48);
      gap_left    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_stamps = {expected_stamps, next_stamp(in_ch.data)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          in_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_words.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 48);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // monitor: ready follows a rotating pattern that is redrawn now and then
  logic [31:0] ready_pat;
  int          pat_left;

  always @(posedge clk) begin
    logic [31:0] pat;
    ccc_out_t    exp_word;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_pat    <= '1;
      pat_left     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_stamps.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected output word: %s", stamp_str(out_ch.data));
          end
          mismatch_count = mismatch_count + 1;
        end else begin
          exp_word = expected_stamps.pop_front();
          if (out_ch.data !== exp_word) begin
            if (mismatch_count < 10) begin
              $display("MISMATCH exp %s", stamp_str(exp_word));
              $display("         got %s", stamp_str(out_ch.data));
            end
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (pat_left == 0) begin
        case ($urandom_range(0, 3))
          0:       pat = '1;
          1:       pat = $urandom;
          2:       pat = $urandom & $urandom;
          default: pat = $urandom | $urandom;
        endcase
        pat_left <= $urandom_range(16, 96);
      end else begin
        pat = {ready_pat[0], ready_pat[31:1]};
        pat_left <= pat_left - 1;
      end
      ready_pat    <= pat;
      out_ch.ready <= pat[0];
    end
  end

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_stamps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
